>>> src/sdcp_pkg.sv
// shared types and constants for the signed decimal command parser
`default_nettype none

package sdcp_pkg;

    // parser phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SKIP    = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    // result status codes
    localparam logic [1:0] ST_VALUE    = 2'd0;
    localparam logic [1:0] ST_NO_NUM   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_BAD_CHAR = 2'd3;

    // byte codes
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] HEADER_RESET = 8'h61;

    localparam int MAG_W  = 31;
    localparam int NUM_W  = 32;
    localparam int BYTE_W = 8;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0]       bad_char;
        logic signed [NUM_W-1:0] number;
        logic [1:0]              status;
    } sdcp_result_t;

endpackage

`default_nettype wire

>>> src/signed_decimal_command_parser.sv
// Signed decimal command parser: takes one received byte per transaction and
// returns at most one result per byte. After the header byte (cfg register,
// reset 'a') it skips blanks, takes an optional minus sign and decimal digits,
// and on CR or LF returns the signed value; it reports no number, overflow
// past 2147483647, or an unexpected byte. Throughput is one byte per clock
// while the result register is free or being emptied; a byte goes through
// an input register, then the accumulator update (magnitude*10 + digit with
// overflow check), then the result register, which offers the result. Both
// stages keep moving while a result waits, as long as the result register
// is free or being emptied in the same cycle.
`default_nettype none

module signed_decimal_command_parser
    import sdcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_data,    // header_char
    // byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] rx_byte
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata      // [1:0] status, [33:2] number,
                                          // [41:34] bad_char, [47:42] zero
);

    logic [BYTE_W-1:0]  header_reg;
    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    sdcp_result_t       result_reg;
    logic               advance;
    logic               step;
    logic               emit;
    sdcp_result_t       result;

    // pipeline control
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? (step && emit) : out_valid_reg;

    // header register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= HEADER_RESET;
        else if (cfg_we)
            header_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    sdcp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .header_char (header_reg),
        .emit        (emit),
        .result      (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, result_reg};

    // a held input byte is not lost while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte dropped during stall");

    // only a value result carries a number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.status != ST_VALUE |-> result_reg.number == '0)
        else $error("number set on error result");

endmodule

`default_nettype wire

>>> src/sdcp_core.sv
// parser state and per-byte update
`default_nettype none

module sdcp_core
    import sdcp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [BYTE_W-1:0]  rx_byte,
    input  wire logic [BYTE_W-1:0]  header_char,
    output logic                    emit,
    output sdcp_result_t            result
);

    phase_t             phase_reg, phase_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               neg_reg, neg_next;

    logic               is_digit;
    logic               is_eol;
    logic               is_blank;
    logic [3:0]         digit;
    logic [MAG_W+3:0]   mag_x10;
    logic               overflow;
    logic [NUM_W-1:0]   mag_ext;

    // byte classes
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_eol   = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB);
    assign digit    = rx_byte[3:0];

    // magnitude*10 + digit, overflow when past 2^31-1
    assign mag_x10  = ({4'd0, mag_reg} << 3) + ({4'd0, mag_reg} << 1)
                      + {{MAG_W{1'b0}}, digit};
    assign overflow = |mag_x10[MAG_W+3:MAG_W];
    assign mag_ext  = {1'b0, mag_reg};

    // next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        emit            = 1'b0;
        result.status   = ST_VALUE;
        result.number   = '0;
        result.bad_char = '0;
        if (step)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    if (is_blank)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (rx_byte == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_COLLECT;
                    end
                    else if (is_digit)
                    begin
                        mag_next   = {{(MAG_W-4){1'b0}}, digit};
                        phase_next = PH_COLLECT;
                    end
                    else if (is_eol)
                    begin
                        emit          = 1'b1;
                        result.status = ST_NO_NUM;
                    end
                end
                PH_COLLECT:
                begin
                    if (is_digit)
                    begin
                        if (overflow)
                        begin
                            emit          = 1'b1;
                            result.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            mag_next = mag_x10[MAG_W-1:0];
                        end
                    end
                    else if (is_eol)
                    begin
                        emit          = 1'b1;
                        result.status = ST_VALUE;
                        result.number = neg_reg ? -mag_ext : mag_ext;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        result.status   = ST_BAD_CHAR;
                        result.bad_char = rx_byte;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == header_char) ? PH_SKIP : PH_IDLE;
                end
            endcase
            // any result clears the line
            if (emit)
            begin
                phase_next = PH_IDLE;
                mag_next   = '0;
                neg_next   = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
        end
    end

    // a result always leaves the parser idle and cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> phase_reg == PH_IDLE && mag_reg == '0 && !neg_reg)
        else $error("parser not cleared after result");

    // magnitude and sign only live while collecting
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_COLLECT |-> mag_reg == '0 && !neg_reg)
        else $error("stale magnitude outside collect phase");

endmodule

`default_nettype wire

>>> tb/sv/tb_signed_decimal_command_parser.sv
// self-checking testbench for the signed decimal command parser
module tb_signed_decimal_command_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import sdcp_pkg::*;

    localparam logic [31:0] MAG_LIMIT = 32'h7FFF_FFFF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_BYTES = 200;

    // line state tracker and store of awaited results
    class line_result_board;
        logic [7:0]       header;
        phase_t           phase;
        logic [MAG_W-1:0] magnitude;
        logic             negative;
        sdcp_result_t     awaited_results[$];
        int               errors;

        function new();
            header = HEADER_RESET;
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase = PH_IDLE;
            magnitude = '0;
            negative = 1'b0;
        endfunction

        function void expect_result(logic [1:0] st, logic [NUM_W-1:0] num, logic [7:0] bad);
            sdcp_result_t r;
            r.status = st;
            r.number = num;
            r.bad_char = bad;
            awaited_results.push_back(r);
            clear_line();
        endfunction

        // advance the line state by one accepted byte
        function void note_byte(logic [7:0] c);
            logic        digit;
            logic        eol;
            logic [31:0] d;
            logic [31:0] mag32;
            logic [31:0] grown;
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            eol = (c == CH_LF) || (c == CH_CR);
            d = {24'b0, c - CH_ZERO};
            mag32 = {1'b0, magnitude};
            case (phase)
                PH_SKIP:
                begin
                    if (c == CH_SPACE || c == CH_TAB)
                    begin
                    end
                    else if (c == CH_MINUS)
                    begin
                        negative = 1'b1;
                        phase = PH_COLLECT;
                    end
                    else if (digit)
                    begin
                        magnitude = d[MAG_W-1:0];
                        phase = PH_COLLECT;
                    end
                    else if (eol)
                        expect_result(ST_NO_NUM, '0, '0);
                end
                PH_COLLECT:
                begin
                    if (digit)
                    begin
                        if (mag32 > (MAG_LIMIT - d) / 10)
                            expect_result(ST_OVERFLOW, '0, '0);
                        else
                        begin
                            grown = mag32 * 10 + d;
                            magnitude = grown[MAG_W-1:0];
                        end
                    end
                    else if (eol)
                        expect_result(ST_VALUE, negative ? (32'd0 - mag32) : mag32, '0);
                    else
                        expect_result(ST_BAD_CHAR, '0, c);
                end
                default:
                begin
                    // unused code behaves as idle
                    phase = PH_IDLE;
                    if (c == header)
                        phase = PH_SKIP;
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // compare one result transaction with the oldest awaited one
        task check_result(logic [47:0] data);
            sdcp_result_t got;
            sdcp_result_t want;
            got = sdcp_result_t'(data[41:0]);
            if (awaited_results.size() == 0)
                report($sformatf("unexpected result status=%0d number=%0d bad_char=%02h",
                                 got.status, got.number, got.bad_char));
            else
            begin
                want = awaited_results.pop_front();
                if (got.status != want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
                if (got.number != want.number)
                    report($sformatf("number %0d, expected %0d", got.number, want.number));
                if (got.bad_char != want.bad_char)
                    report($sformatf("bad_char %02h, expected %02h",
                                     got.bad_char, want.bad_char));
                if (data[47:42] != '0)
                    report($sformatf("padding bits %b not zero", data[47:42]));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    line_result_board board;
    logic [7:0] byte_q[$];
    int         idle_count;
    int         burst_left;
    bit         steady_sender;
    int         rx_mode;
    int         rx_left;
    int         rx_stall;
    int         rx_tick;

    signed_decimal_command_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // transaction monitor on both sides
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_count = 0;
            else
                idle_count++;
        end
    end

    // receiver stall pattern, switching between randomly chosen modes
    always @(negedge clk)
    begin
        logic ready;
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: ready = 1'b1;
            1: ready = $urandom_range(0, 1);
            2: ready = (rx_tick % 4) != 0;
            default:
            begin
                if (rx_stall > 0)
                begin
                    ready = 1'b0;
                    rx_stall--;
                end
                else
                begin
                    ready = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_stall = $urandom_range(5, 20);
                end
            end
        endcase
        m_tready <= ready;
    end

    // send one byte, with bursts and random gaps
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = steady_sender ? 0 : $urandom_range(0, 12);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_queued();
        while (byte_q.size() != 0)
            send_byte(byte_q.pop_front());
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // wait until every awaited result is in and the pipeline is empty
    task automatic drain();
        @(posedge clk);
        while (board.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_header(input logic [7:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        board.header = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    // digits of one number: short, long, near the limit or with leading zeros
    task automatic add_digits(inout logic [7:0] ln[$]);
        int    pick;
        int    n;
        longint v;
        string s;
        pick = $urandom_range(0, 9);
        if (pick >= 6 && pick <= 8)
        begin
            v = 64'd2147483647 + longint'($urandom_range(0, 20)) - 10;
            s = $sformatf("%0d", v);
            for (int i = 0; i < s.len(); i++)
                ln.push_back(s[i]);
        end
        else
        begin
            if (pick == 9)
                repeat ($urandom_range(1, 12)) ln.push_back(CH_ZERO);
            n = (pick < 4 || pick == 9) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            repeat (n) ln.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // one command line, optionally damaged
    task automatic add_line(input bit broken);
        logic [7:0] ln[$];
        logic [7:0] junk;
        int         pos;
        ln.push_back(board.header);
        repeat ($urandom_range(0, 3)) ln.push_back(blank_byte());
        // a byte that is ignored while skipping blanks
        if ($urandom_range(0, 7) == 0)
        begin
            do
                junk = $urandom_range(0, 255);
            while (junk == CH_SPACE || junk == CH_TAB || junk == CH_MINUS ||
                   junk == CH_LF || junk == CH_CR || (junk >= CH_ZERO && junk <= CH_NINE));
            ln.push_back(junk);
            repeat ($urandom_range(0, 2)) ln.push_back(blank_byte());
        end
        if ($urandom_range(0, 1))
            ln.push_back(CH_MINUS);
        if ($urandom_range(0, 9) != 0)
            add_digits(ln);
        case ($urandom_range(0, 3))
            0: ln.push_back(CH_CR);
            1: begin ln.push_back(CH_CR); ln.push_back(CH_LF); end
            default: ln.push_back(CH_LF);
        endcase
        if (broken)
        begin
            pos = $urandom_range(1, ln.size() - 1);
            case ($urandom_range(0, 3))
                0: ln.insert(pos, CH_MINUS);
                1: ln.insert(pos, blank_byte());
                2: ln.insert(pos, 8'($urandom_range(0, 255)));
                default: ln = ln[0:pos-1];
            endcase
        end
        foreach (ln[i])
            byte_q.push_back(ln[i]);
    endtask

    // one phase of random lines and noise
    task automatic build_phase();
        int kind;
        while (byte_q.size() < PHASE_BYTES)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 15)
                add_line(1'b0);
            else if (kind < 17)
                add_line(1'b1);
            else
                repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // stall watchdog
    initial
    begin
        @(posedge clk);
        while (idle_count < STALL_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [7:0] headers[8];
        board = new();
        idle_count = 0;
        burst_left = 0;
        steady_sender = 1'b0;
        rx_mode = 0;
        rx_left = 0;
        rx_stall = 0;
        rx_tick = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed lines under the reset header
        push_text("a\t-\n");          // minus sign alone
        push_text("a\r");             // line end before any number
        push_text("ax\n");            // other byte ignored while skipping
        push_text("a12-");            // minus sign while collecting
        push_text("a1a");             // header byte while collecting
        push_text("a2147483648");     // overflow on the last digit
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        send_queued();

        headers = '{8'h00, 8'hFF, CH_MINUS, CH_ZERO + 8'd5, CH_LF, CH_SPACE,
                    8'($urandom_range(0, 255)), HEADER_RESET};
        foreach (headers[i])
        begin
            drain();
            write_header(headers[i]);
            steady_sender = ($urandom_range(0, 3) == 0);
            build_phase();
            send_queued();
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.awaited_results.size() != 0)
            board.report($sformatf("%0d results never arrived", board.awaited_results.size()));
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
src/sdcp_pkg.sv
src/sdcp_core.sv
src/signed_decimal_command_parser.sv
tb/sv/tb_signed_decimal_command_parser.sv
